// File: design/rgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared widths and item types for the rectangle gap distance block.
// ----------------------------------------------------------------------------
package rgd_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int FRAC_BITS    = 4;
   localparam int OUT_WIDTH    = COORD_WIDTH + FRAC_BITS + 1;
   localparam int SQ_WIDTH     = 2 * COORD_WIDTH;
   localparam int SUM_WIDTH    = 2 * COORD_WIDTH + 2;
   localparam int ROOT_STEPS   = OUT_WIDTH;
   localparam int REM_WIDTH    = OUT_WIDTH + 2;
   localparam int BACK_LATENCY = ROOT_STEPS + 2;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_left;
      logic signed [COORD_WIDTH-1:0] a_right;
      logic signed [COORD_WIDTH-1:0] a_top;
      logic signed [COORD_WIDTH-1:0] a_bottom;
      logic signed [COORD_WIDTH-1:0] b_left;
      logic signed [COORD_WIDTH-1:0] b_right;
      logic signed [COORD_WIDTH-1:0] b_top;
      logic signed [COORD_WIDTH-1:0] b_bottom;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] gap_distance;
      logic                 boxes_overlap;
   } rsp_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] dx;
      logic [COORD_WIDTH-1:0] dy;
      logic                   overlap;
   } job_type;

endpackage
`default_nettype wire

// File: design/rgd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgd_front
// Accepts box pairs, decides overlap and computes the per-axis gaps.
// ----------------------------------------------------------------------------
module rgd_front
   import rgd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_boxes,
   input  wire logic    queue_full,
   output logic         job_valid,
   output job_type      job
);

   function automatic logic [COORD_WIDTH-1:0] axis_gap(
      input logic signed [COORD_WIDTH-1:0] lo1,
      input logic signed [COORD_WIDTH-1:0] hi1,
      input logic signed [COORD_WIDTH-1:0] lo2,
      input logic signed [COORD_WIDTH-1:0] hi2
   );
      logic [COORD_WIDTH:0] diff;
      logic [COORD_WIDTH-1:0] gap;
      diff = '0;
      gap  = '0;
      if (lo1 >= hi2) begin
         diff = {lo1[COORD_WIDTH-1], lo1} - {hi2[COORD_WIDTH-1], hi2};
         gap  = diff[COORD_WIDTH-1:0];
      end else if (lo2 >= hi1) begin
         diff = {lo2[COORD_WIDTH-1], lo2} - {hi1[COORD_WIDTH-1], hi1};
         gap  = diff[COORD_WIDTH-1:0];
      end
      return gap;
   endfunction

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    accept;
   logic    push;
   logic    overlap_x, overlap_y;

   assign busy   = valid_ff && queue_full;
   assign accept = start && !busy;
   assign push   = valid_ff && !queue_full;

   assign overlap_x = !(req_boxes.a_left >= req_boxes.b_right ||
                        req_boxes.b_left >= req_boxes.a_right);
   assign overlap_y = !(req_boxes.a_top >= req_boxes.b_bottom ||
                        req_boxes.b_top >= req_boxes.a_bottom);

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (accept) begin
         valid_in       = 1'b1;
         job_in.dx      = axis_gap(req_boxes.a_left, req_boxes.a_right,
                                   req_boxes.b_left, req_boxes.b_right);
         job_in.dy      = axis_gap(req_boxes.a_top, req_boxes.a_bottom,
                                   req_boxes.b_top, req_boxes.b_bottom);
         job_in.overlap = overlap_x && overlap_y;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule
`default_nettype wire

// File: design/rgd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgd_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rgd_queue
   import rgd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_job,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job
);

   job_type               entry_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign full = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign push = push_valid && !full;
   assign pop  = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = pop;
   assign head_job   = entry_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

endmodule
`default_nettype wire

// File: design/rgd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgd_back
// Squares and sums the axis gaps, then takes a pipelined fixed-point root,
// one result bit per stage.
// ----------------------------------------------------------------------------
module rgd_back
   import rgd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         rsp_strobe,
   output rsp_type      rsp_result
);

   logic                 sq_valid_ff;
   logic [SQ_WIDTH-1:0]  sqx_ff, sqx_in;
   logic [SQ_WIDTH-1:0]  sqy_ff, sqy_in;
   logic                 sq_ovl_ff;

   logic                 sum_valid_ff;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic                 sum_ovl_ff;

   logic                 cur_valid [0:ROOT_STEPS-1];
   logic                 cur_ovl   [0:ROOT_STEPS-1];
   logic [REM_WIDTH-1:0] cur_rem   [0:ROOT_STEPS-1];
   logic [OUT_WIDTH-1:0] cur_root  [0:ROOT_STEPS-1];
   logic [SUM_WIDTH-1:0] cur_s     [0:ROOT_STEPS-1];

   logic                 valid_ff  [0:ROOT_STEPS-1];
   logic                 ovl_ff    [0:ROOT_STEPS-1];
   logic [OUT_WIDTH-1:0] root_ff   [0:ROOT_STEPS-1];
   logic [REM_WIDTH-1:0] rem_ff    [0:ROOT_STEPS-2];
   logic [SUM_WIDTH-1:0] s_ff      [0:ROOT_STEPS-2];

   assign sqx_in = SQ_WIDTH'(job.dx) * SQ_WIDTH'(job.dx);
   assign sqy_in = SQ_WIDTH'(job.dy) * SQ_WIDTH'(job.dy);
   assign sum_in = SUM_WIDTH'(sqx_ff) + SUM_WIDTH'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= job_valid;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      sq_ovl_ff  <= job.overlap;
      sum_ff     <= sum_in;
      sum_ovl_ff <= sq_ovl_ff;
   end

   assign cur_valid[0] = sum_valid_ff;
   assign cur_ovl[0]   = sum_ovl_ff;
   assign cur_rem[0]   = '0;
   assign cur_root[0]  = '0;
   assign cur_s[0]     = sum_ff;

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      logic [REM_WIDTH-1:0] rem_sh;
      logic [REM_WIDTH-1:0] trial;
      logic                 fits;
      logic [REM_WIDTH-1:0] rem_in;
      logic [OUT_WIDTH-1:0] root_in;

      assign rem_sh  = {cur_rem[k][REM_WIDTH-3:0], cur_s[k][SUM_WIDTH-1 -: 2]};
      assign trial   = {cur_root[k], 2'b01};
      assign fits    = (rem_sh >= trial);
      assign rem_in  = fits ? rem_sh - trial : rem_sh;
      assign root_in = {cur_root[k][OUT_WIDTH-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= cur_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         root_ff[k] <= root_in;
         ovl_ff[k]  <= cur_ovl[k];
      end

      if (k < ROOT_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            s_ff[k]   <= {cur_s[k][SUM_WIDTH-3:0], 2'b00};
         end

         assign cur_valid[k+1] = valid_ff[k];
         assign cur_ovl[k+1]   = ovl_ff[k];
         assign cur_rem[k+1]   = rem_ff[k];
         assign cur_root[k+1]  = root_ff[k];
         assign cur_s[k+1]     = s_ff[k];
      end
   end

   assign rsp_strobe               = valid_ff[ROOT_STEPS-1];
   assign rsp_result.gap_distance  = root_ff[ROOT_STEPS-1];
   assign rsp_result.boxes_overlap = ovl_ff[ROOT_STEPS-1];

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> ##BACK_LATENCY rsp_strobe)
      else $error("item did not leave the root pipeline on time");

   a_overlap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_result.boxes_overlap |-> rsp_result.gap_distance == '0)
      else $error("overlapping boxes gave a nonzero gap");

endmodule
`default_nettype wire

// File: design/rect_gap_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_gap_distance
// Euclidean gap between two axis-aligned boxes, with an overlap flag.
// ----------------------------------------------------------------------------
// A new box pair can be started in every cycle; busy stays low as long as
// the result side drains, which it always does since results cannot be
// held off. Each item gives exactly one result, shown on rsp_result for one
// cycle with rsp_strobe. On its way the item passes the classifying front
// register, the queue, the squares register, the sum register and then
// each stage of the 21-stage root pipeline, one per result bit.
// Results leave in the order the items were accepted.
// ----------------------------------------------------------------------------
module rect_gap_distance
   import rgd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_boxes,
   output logic         rsp_strobe,
   output rsp_type      rsp_result
);

   logic    front_valid;
   job_type front_job;
   logic    queue_full;
   logic    head_valid;
   job_type head_job;

   rgd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_boxes  (req_boxes),
      .queue_full (queue_full),
      .job_valid  (front_valid),
      .job        (front_job)
   );

   rgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_job   (front_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   rgd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .rsp_strobe (rsp_strobe),
      .rsp_result (rsp_result)
   );

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("block stalled although the back drains every cycle");

   a_end_to_end: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(BACK_LATENCY + 2) rsp_strobe)
      else $error("accepted item produced no result on time");

endmodule
`default_nettype wire
